>>> src/tar_pkg.sv
// Package for the tensor axis reduction block: mode codes, states, command structs.
// Used by tar_ctrl, tar_dp and tensor_axis_reduction.
`timescale 1ns / 1ps
package tar_pkg;
    localparam int MaxRowLength = 1024;
    localparam int PosW = $clog2(MaxRowLength);

    typedef enum logic [2:0] {
        MODE_MAX  = 3'd0,
        MODE_MIN  = 3'd1,
        MODE_SUM  = 3'd2,
        MODE_PROD = 3'd3,
        MODE_L2   = 3'd4,
        MODE_MEAN = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_GROUPS = 2'd1,
        REG_ROWS   = 2'd2,
        REG_LENGTH = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_ITER,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic             load;      // capture element and position
        logic             calc;      // combine and write back
        logic             first_row;
        logic             emit;
        logic             iter;      // one step of sqrt / divide
        logic [PosW-1:0]  idx;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_iter;
        logic iter_done;
    } dp_stat_t;
endpackage

>>> src/tar_dp.sv
// Datapath: accumulator memory, combine unit, shared bit-serial sqrt / divide.
// Depends on tar_pkg.
`timescale 1ns / 1ps
module tar_dp import tar_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    input  logic [2:0]         mode,
    input  logic [15:0]        rc,
    input  logic signed [31:0] s_element,
    output logic signed [31:0] res,
    output logic               inv
);
    logic [31:0] mem [MaxRowLength];
    logic [31:0] rd_reg;
    logic [31:0] x_reg;
    logic [31:0] acc_reg;
    logic [31:0] prod_reg;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [31:0] q_reg, q_next;
    logic [5:0]  cnt_reg;
    logic        neg_reg;
    logic [31:0] a0, acc_new, mag;
    logic [32:0] trial;
    logic [31:0] res_next;
    logic        inv_next;
    logic [2:0]  m;

    assign m = (mode <= 3'(MODE_MEAN)) ? mode : 3'(MODE_MAX);

    // read entry and precompute the square for L2 mode
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg  <= s_element;
            rd_reg <= mem[cmd.idx];
            prod_reg <= (m == 3'(MODE_L2)) ? s_element * s_element : 32'd0;
        end
    end

    always_comb begin
        unique case (m)
            3'(MODE_MIN):  a0 = 32'h7FFF_FFFF;
            3'(MODE_PROD): a0 = 32'd1;
            3'(MODE_MAX):  a0 = 32'h8000_0001;
            default:       a0 = 32'd0;
        endcase
        if (!cmd.first_row) a0 = rd_reg;
        unique case (m)
            3'(MODE_MIN):  acc_new = ($signed(x_reg) < $signed(a0)) ? x_reg : a0;
            3'(MODE_PROD): acc_new = a0 * x_reg;
            3'(MODE_L2):   acc_new = a0 + prod_reg;
            3'(MODE_SUM), 3'(MODE_MEAN): acc_new = a0 + x_reg;
            default:       acc_new = ($signed(x_reg) > $signed(a0)) ? x_reg : a0;
        endcase
        mag = acc_new[31] ? (~acc_new + 32'd1) : acc_new;
    end

    // write back, seed iterative unit
    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            mem[cmd.idx] <= acc_new;
            acc_reg <= acc_new;
            neg_reg <= acc_new[31];
            cnt_reg <= 6'd0;
            root_reg <= 32'd0;
            q_reg <= (m == 3'(MODE_L2)) ? acc_new : mag;
            rem_reg <= 32'd0;
        end else if (cmd.iter) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            q_reg    <= q_next;
            cnt_reg  <= cnt_reg + 6'd1;
        end
    end

    // one step: sqrt takes two bits per step (16 steps), divide one bit (32 steps)
    always_comb begin
        rem_next  = rem_reg;
        root_next = root_reg;
        q_next    = q_reg;
        trial     = 33'd0;
        if (m == 3'(MODE_L2)) begin
            rem_next = {rem_reg[29:0], q_reg[31:30]};
            q_next   = {q_reg[29:0], 2'b00};
            trial    = {1'b0, rem_next} - {1'b0, root_reg[29:0], 2'b01};
            if (!trial[32]) begin
                rem_next  = trial[31:0];
                root_next = {root_reg[30:0], 1'b1};
            end else begin
                root_next = {root_reg[30:0], 1'b0};
            end
        end else begin
            rem_next = {rem_reg[30:0], q_reg[31]};
            trial    = {1'b0, rem_next} - {17'd0, rc};
            if (!trial[32]) begin
                rem_next = trial[31:0];
                q_next   = {q_reg[30:0], 1'b1};
            end else begin
                q_next   = {q_reg[30:0], 1'b0};
            end
        end
    end

    assign stat.need_iter = (m == 3'(MODE_L2) && !neg_reg) || m == 3'(MODE_MEAN);
    assign stat.iter_done = (m == 3'(MODE_L2)) ? (cnt_reg == 6'd15) : (cnt_reg == 6'd31);

    always_comb begin
        inv_next = 1'b0;
        res_next = acc_reg;
        if (m == 3'(MODE_L2)) begin
            if (neg_reg) begin
                inv_next = 1'b1;
                res_next = 32'd0;
            end else begin
                res_next = root_reg;
            end
        end else if (m == 3'(MODE_MEAN)) begin
            res_next = neg_reg ? (~q_reg + 32'd1) : q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            res <= res_next;
            inv <= inv_next;
        end
    end

    logic unused_rst;
    assign unused_rst = aresetn;
endmodule

>>> src/tar_ctrl.sv
// Controller: counters, handshake sequencing and result valid.
// Depends on tar_pkg.
`timescale 1ns / 1ps
module tar_ctrl import tar_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] group_count,
    input  logic [15:0] row_count,
    input  logic [10:0] row_length,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_last,
    output dp_cmd_t     cmd,
    input  dp_stat_t    stat
);
    state_t state_reg, state_next;
    logic [10:0] pos_reg, pos_next;
    logic [15:0] row_reg, row_next;
    logic [15:0] grp_reg, grp_next;
    logic        mv_reg, mv_next;
    logic        last_reg, last_next;
    logic [10:0] len;
    logic [15:0] rc, gc;
    logic        emit, last_pos, last_grp;

    assign rc  = (row_count == 16'd0) ? 16'd1 : row_count;
    assign gc  = (group_count == 16'd0) ? 16'd1 : group_count;
    assign len = (row_length == 11'd0) ? 11'd1 :
                 (row_length > 11'(MaxRowLength)) ? 11'(MaxRowLength) : row_length;
    assign emit     = row_reg >= rc - 16'd1;
    assign last_pos = pos_reg >= len - 11'd1;
    assign last_grp = grp_reg >= gc - 16'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg <= '0;
            row_reg <= '0;
            grp_reg <= '0;
            mv_reg <= 1'b0;
            last_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pos_reg <= pos_next;
            row_reg <= row_next;
            grp_reg <= grp_next;
            mv_reg <= mv_next;
            last_reg <= last_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pos_next = pos_reg;
        row_next = row_reg;
        grp_next = grp_reg;
        mv_next = mv_reg && !m_ready;
        last_next = last_reg;
        s_ready = 1'b0;
        cmd = '0;
        cmd.idx = (pos_reg >= 11'(MaxRowLength)) ? PosW'(MaxRowLength - 1) : pos_reg[PosW-1:0];
        cmd.first_row = (row_reg == 16'd0);
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                cmd.calc = 1'b1;
                if (!emit) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (stat.need_iter) state_next = ST_ITER;
                else state_next = ST_OUT;
            end
            ST_ITER: begin
                cmd.iter = 1'b1;
                if (stat.iter_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                // wait until the output register is free
                if (!mv_reg || m_ready) begin
                    cmd.emit = 1'b1;
                    mv_next = 1'b1;
                    last_next = last_pos && last_grp;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // advance counters once the element is combined
        if ((state_reg == ST_CALC && !emit) || cmd.emit) begin
            if (last_pos) begin
                pos_next = '0;
                if (emit) begin
                    row_next = '0;
                    grp_next = last_grp ? 16'd0 : grp_reg + 16'd1;
                end else begin
                    row_next = row_reg + 16'd1;
                end
            end else begin
                pos_next = pos_reg + 11'd1;
            end
        end
    end

    assign m_valid = mv_reg;
    assign m_last  = last_reg;
endmodule

>>> src/tensor_axis_reduction.sv
// Usage: stream signed 32-bit elements on s_element/s_valid/s_ready in group,
// row, position order. Results leave on m_reduced/m_invalid/m_last with
// m_valid/m_ready, one per element of a group's last row.
// Configure mode, group_count, row_count, row_length through the APB port
// (byte addresses 0, 4, 8, 12) only while no transfer is in flight.
// Non-final-row elements pass ST_IDLE (read) and ST_CALC (combine); final-row
// elements add ST_READ and ST_OUT, with ST_ITER in between for the bit-serial
// square root (L2 mode) or divider (mean mode). Elements enter only in ST_IDLE.
// Accumulators live in a 1024-entry memory; no clearing pass is needed since
// the first row of each group overwrites them.
// Reset (aresetn low, synchronous) clears controller state and counters and sets
// the APB registers to defaults. A stalled receiver holds the result register;
// then the next final-row element goes up to its result and waits for m_ready.
`timescale 1ns / 1ps
module tensor_axis_reduction import tar_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic signed [31:0] s_element,
    input  logic               s_valid,
    output logic               s_ready,
    output logic signed [31:0] m_reduced,
    output logic               m_invalid,
    output logic               m_last,
    output logic               m_valid,
    input  logic               m_ready
);
    logic [2:0]  mode_reg;
    logic [15:0] groups_reg, rows_reg;
    logic [10:0] length_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    reg_idx_t    ridx;
    logic [15:0] rc;

    assign pready = 1'b1;
    assign ridx = reg_idx_t'(paddr[3:2]);

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 3'd0;
            groups_reg <= 16'd1;
            rows_reg <= 16'd1;
            length_reg <= 11'd1;
        end else if (psel && penable && pwrite) begin
            unique case (ridx)
                REG_MODE:   mode_reg <= pwdata[2:0];
                REG_GROUPS: groups_reg <= pwdata[15:0];
                REG_ROWS:   rows_reg <= pwdata[15:0];
                REG_LENGTH: length_reg <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (ridx)
            REG_MODE:   prdata = {29'd0, mode_reg};
            REG_GROUPS: prdata = {16'd0, groups_reg};
            REG_ROWS:   prdata = {16'd0, rows_reg};
            REG_LENGTH: prdata = {21'd0, length_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign rc = (rows_reg == 16'd0) ? 16'd1 : rows_reg;

    tar_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .group_count(groups_reg), .row_count(rows_reg), .row_length(length_reg),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .m_last(m_last),
        .cmd(cmd), .stat(stat)
    );

    tar_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .mode(mode_reg), .rc(rc), .s_element(s_element),
        .res(m_reduced), .inv(m_invalid)
    );
endmodule
